### hdl/assert_macros.svh
// Assertion macros for the RTL modules, used by the serialiser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sida_pkg.sv
// Shared constants, types and payload structs for the decimal text converter
`default_nettype none

package sida_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int DIGITS         = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS       = 4 * DIGITS;
  localparam int IDX_BITS       = $clog2(DIGITS);
  localparam int STEP           = 8;
  localparam int DABBLE_STAGES  = (VALUE_BITS + STEP - 1) / STEP;
  localparam int MAG_BITS       = DABBLE_STAGES * STEP;
  localparam int CHAR_BITS      = 6;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic [BCD_BITS-1:0]          bcd_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CHAR_BITS-1:0]         char_t;

  localparam char_t CHAR_MINUS = char_t'(45);
  localparam char_t CHAR_ZERO  = char_t'(48);
  localparam char_t CHAR_NINE  = char_t'(57);

  typedef struct packed {
    logic sign;
    bcd_t bcd;
    mag_t mag;
  } dabble_t;

  typedef struct packed {
    logic sign;
    bcd_t bcd;
    idx_t top;
  } scan_t;

endpackage

`default_nettype wire

### hdl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter, top level
//
// Converts each accepted signed value into its decimal text, one ASCII
// character per result item, most significant first: a minus sign for a
// negative value, then the digits with leading zeros removed ('0' alone for
// zero); last marks the final character. The most negative value converts
// exactly. A value goes through a magnitude stage, four binary-to-BCD stages
// of eight bits each and a leading-digit stage before the serialiser. The
// output gives one character per cycle while out_ready allows, 1 to 11
// characters per value, and sets the sustained rate; the stages in front
// hold up to six further values.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sida_pkg::value_t value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sida_pkg::char_t       character,
  output logic                  last
);

  localparam int NS = sida_pkg::DABBLE_STAGES;

  logic                   stage_valid;
  sida_pkg::dabble_t      stage_data;
  sida_pkg::value_t       neg;

  logic                   dv [NS+1];
  logic                   dr [NS+1];
  sida_pkg::dabble_t      dd [NS+1];

  logic                   scan_valid;
  logic                   scan_ready;
  sida_pkg::scan_t        scan_data;

  assign neg      = -value;
  assign in_ready = !stage_valid || dr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_data.sign <= value[sida_pkg::VALUE_BITS-1];
      stage_data.bcd  <= '0;
      stage_data.mag  <= value[sida_pkg::VALUE_BITS-1] ?
                         sida_pkg::mag_t'(unsigned'(neg)) :
                         sida_pkg::mag_t'(unsigned'(value));
    end
  end

  assign dv[0] = stage_valid;
  assign dd[0] = stage_data;

  for (genvar g = 0; g < NS; g++) begin : g_dabble
    sida_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_data   (dd[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_data  (dd[g+1])
    );
  end

  sida_lead_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[NS]),
    .in_ready  (dr[NS]),
    .in_data   (dd[NS]),
    .out_valid (scan_valid),
    .out_ready (scan_ready),
    .out_data  (scan_data)
  );

  sida_serialiser u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scan_valid),
    .in_ready  (scan_ready),
    .in_data   (scan_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

endmodule

`default_nettype wire

### hdl/sida_dabble_stage.sv
// One pipeline stage of the binary to BCD shift-and-add-3 conversion
`default_nettype none

module sida_dabble_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sida_pkg::dabble_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sida_pkg::dabble_t      out_data
);

  sida_pkg::dabble_t step_data;

  always_comb begin
    sida_pkg::bcd_t b;
    sida_pkg::mag_t m;
    logic           msb;
    b = in_data.bcd;
    m = in_data.mag;
    for (int s = 0; s < sida_pkg::STEP; s++) begin
      for (int k = 0; k < sida_pkg::DIGITS; k++) begin
        if (b[4*k +: 4] >= 4'd5) begin
          b[4*k +: 4] = b[4*k +: 4] + 4'd3;
        end
      end
      msb = m[sida_pkg::MAG_BITS-1];
      m   = {m[sida_pkg::MAG_BITS-2:0], 1'b0};
      b   = {b[sida_pkg::BCD_BITS-2:0], msb};
    end
    step_data.sign = in_data.sign;
    step_data.bcd  = b;
    step_data.mag  = m;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step_data;
    end
  end

endmodule

`default_nettype wire

### hdl/sida_lead_scan.sv
// Pipeline stage that finds the most significant non-zero digit
`default_nettype none

module sida_lead_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sida_pkg::dabble_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sida_pkg::scan_t        out_data
);

  sida_pkg::idx_t top;

  always_comb begin
    top = '0;
    for (int k = 0; k < sida_pkg::DIGITS; k++) begin
      if (in_data.bcd[4*k +: 4] != 4'd0) begin
        top = sida_pkg::idx_t'(k);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.sign <= in_data.sign;
      out_data.bcd  <= in_data.bcd;
      out_data.top  <= top;
    end
  end

endmodule

`default_nettype wire

### hdl/sida_serialiser.sv
// Emits the sign and digits of one item as characters, one per cycle unless the output stalls
`default_nettype none

`include "assert_macros.svh"

module sida_serialiser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sida_pkg::scan_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sida_pkg::char_t      character,
  output logic                 last
);

  logic           busy;
  logic           sign_pend;
  sida_pkg::idx_t idx;
  sida_pkg::bcd_t bcd;

  logic out_free;
  logic emit;
  logic finishing;
  logic [3:0] digit;

  assign out_free  = !out_valid || out_ready;
  assign emit      = busy && out_free;
  assign finishing = emit && !sign_pend && (idx == '0);
  assign in_ready  = !busy || finishing;
  assign digit     = bcd[4*idx +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (sign_pend) begin
        character <= sida_pkg::CHAR_MINUS;
        last      <= 1'b0;
        sign_pend <= 1'b0;
      end else begin
        character <= sida_pkg::CHAR_ZERO + sida_pkg::char_t'(digit);
        last      <= (idx == '0);
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
    end
    if (in_valid && in_ready) begin
      sign_pend <= in_data.sign;
      idx       <= in_data.top;
      bcd       <= in_data.bcd;
    end
  end

  `ASSERT_ALL(a_reset_idle, rst |=> !out_valid, "output valid after reset")
  `ASSERT_RUN(a_last_is_digit, out_valid && last |-> character != sida_pkg::CHAR_MINUS,
              "last marker on a minus sign")
  `ASSERT_RUN(a_minus_then_digit,
              out_valid && out_ready && character == sida_pkg::CHAR_MINUS
              |=> out_valid && character != sida_pkg::CHAR_MINUS,
              "minus sign not followed by a digit")
  `ASSERT_RUN(a_char_range,
              out_valid |-> character == sida_pkg::CHAR_MINUS ||
              (character >= sida_pkg::CHAR_ZERO && character <= sida_pkg::CHAR_NINE),
              "character outside the digit range")

endmodule

`default_nettype wire

### tb/sv/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed integer to decimal ASCII text converter
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 250;
  localparam int N_ROWS       = 20;

  typedef struct {
    sida_pkg::char_t ch;
    logic            lst;
  } text_char_t;

  typedef struct {
    sida_pkg::value_t v;
    string            txt;
  } row_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  sida_pkg::value_t value     = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sida_pkg::char_t  character;
  logic             last;

  text_char_t text_q [$];
  int mismatches    = 0;
  int cycles        = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 58;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  // empty text: expected characters come from the predictor
  row_t dir_rows [N_ROWS] = '{
    '{sida_pkg::value_t'(0),            "0"},
    '{sida_pkg::value_t'(1),            "1"},
    '{sida_pkg::value_t'(-1),           "-1"},
    '{sida_pkg::value_t'(9),            "9"},
    '{sida_pkg::value_t'(10),           "10"},
    '{sida_pkg::value_t'(-10),          "-10"},
    '{sida_pkg::value_t'(32'h7fffffff), "2147483647"},
    '{sida_pkg::value_t'(32'h80000000), "-2147483648"},
    '{sida_pkg::value_t'(32'h80000001), "-2147483647"},
    '{sida_pkg::value_t'(1000000000),   "1000000000"},
    '{sida_pkg::value_t'(-999999999),   "-999999999"},
    '{sida_pkg::value_t'(99),           ""},
    '{sida_pkg::value_t'(100),          ""},
    '{sida_pkg::value_t'(12345),        ""},
    '{sida_pkg::value_t'(-54321),       ""},
    '{sida_pkg::value_t'(32'h55555555), ""},
    '{sida_pkg::value_t'(32'haaaaaaaa), ""},
    '{sida_pkg::value_t'(999999999),    ""},
    '{sida_pkg::value_t'(-100000),      ""},
    '{sida_pkg::value_t'(7),            ""}
  };

  signed_int_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void queue_decimal_text(sida_pkg::value_t v);
    logic [sida_pkg::VALUE_BITS-1:0] mag;
    logic [3:0] digits [$];
    text_char_t c;
    mag = v[sida_pkg::VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[sida_pkg::VALUE_BITS-1]) begin
      c.ch  = sida_pkg::CHAR_MINUS;
      c.lst = 1'b0;
      text_q.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch  = sida_pkg::CHAR_ZERO + sida_pkg::char_t'(digits[i]);
      c.lst = (i == digits.size() - 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic void queue_typed_text(string s);
    text_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.ch  = sida_pkg::char_t'(s[i]);
      c.lst = (i == s.len() - 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic sida_pkg::value_t pick_value();
    sida_pkg::value_t v;
    longint p;
    int k;
    p = 1;
    case ($urandom_range(0, 5))
      1: v = sida_pkg::value_t'($urandom_range(0, 20));
      2: begin
        k = $urandom_range(1, 9);
        repeat (k) p = p * 10;
        v = sida_pkg::value_t'(p + $urandom_range(0, 2) - 1);
      end
      3: v = $urandom_range(0, 1) ? sida_pkg::value_t'(32'h80000000 + $urandom_range(0, 15))
                                  : sida_pkg::value_t'(32'h7fffffff - $urandom_range(0, 15));
      4: v = sida_pkg::value_t'($urandom >> $urandom_range(0, 31));
      default: v = sida_pkg::value_t'($urandom);
    endcase
    if ($urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_value(sida_pkg::value_t v, string txt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (txt.len() == 0) queue_decimal_text(v);
    else queue_typed_text(txt);
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: character %0d last %0b", character, last);
      end else begin
        want = text_q.pop_front();
        if (character !== want.ch || last !== want.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected character %0d last %0b, got %0d last %0b",
                     want.ch, want.lst, character, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_value(dir_rows[i].v, dir_rows[i].txt);
    repeat (RANDOM_ITEMS / 3) send_value(pick_value(), "");

    send_idle_pct = 58;
    recv_idle_pct = 9;
    repeat (RANDOM_ITEMS / 3) send_value(pick_value(), "");

    // long output stall while items keep coming, to back up the pipeline
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (RANDOM_ITEMS / 3) send_value(pick_value(), "");
    in_valid <= 1'b0;

    while (text_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/sida_pkg.sv
hdl/sida_dabble_stage.sv
hdl/sida_lead_scan.sv
hdl/sida_serialiser.sv
hdl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
